// File: hdl/s16c_pkg.sv
// Package for the 16-bit CPU core: host function codes, fault codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package s16c_pkg;

   typedef enum logic [2:0] {
      FUNC_WRITE_MEM = 3'd0,
      FUNC_READ_MEM  = 3'd1,
      FUNC_READ_REG  = 3'd2,
      FUNC_START     = 3'd3,
      FUNC_EXECUTE   = 3'd4
   } func_type;

   localparam logic [2:0] FAULT_NONE  = 3'd0;
   localparam logic [2:0] FAULT_OPC   = 3'd1;
   localparam logic [2:0] FAULT_READ  = 3'd2;
   localparam logic [2:0] FAULT_WRITE = 3'd3;
   localparam logic [2:0] FAULT_JUMP  = 3'd4;
   localparam logic [2:0] FAULT_FETCH = 3'd5;

   localparam logic [15:0] STOP_WORD = 16'h3800;

   localparam logic [1:0] CLS_MOVE  = 2'd0;
   localparam logic [1:0] CLS_ALU   = 2'd1;
   localparam logic [1:0] CLS_JUMP  = 2'd2;
   localparam logic [1:0] CLS_BRNCH = 2'd3;

   localparam logic [2:0] MV_MOV   = 3'd0;
   localparam logic [2:0] MV_LOAD  = 3'd1;
   localparam logic [2:0] MV_STORE = 3'd2;
   localparam logic [2:0] MV_MOVL  = 3'd4;
   localparam logic [2:0] MV_MOVH  = 3'd5;
   localparam logic [2:0] MV_NOP   = 3'd7;

   localparam logic [4:0] ALU_ADD  = 5'd0;
   localparam logic [4:0] ALU_SUB  = 5'd1;
   localparam logic [4:0] ALU_OR   = 5'd2;
   localparam logic [4:0] ALU_AND  = 5'd3;
   localparam logic [4:0] ALU_XOR  = 5'd4;
   localparam logic [4:0] ALU_COMP = 5'd7;
   localparam logic [4:0] ALU_NOT  = 5'd8;
   localparam logic [4:0] ALU_INC  = 5'd9;
   localparam logic [4:0] ALU_DEC  = 5'd10;
   localparam logic [4:0] ALU_NEG  = 5'd11;
   localparam logic [4:0] ALU_CLR  = 5'd12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;    // write zero at clear address, advance it
      logic host_write;  // write host data to memory
      logic host_read;   // read memory at host address
      logic reg_read;    // latch register for response
      logic start;       // reload pc, clear flags, fault and halt
      logic fetch;       // issue instruction fetch at pc
      logic exec;        // decode and execute fetched word
      logic load_wb;     // write load data to register
      logic rsp;         // present response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic halted;
      logic fetch_ok;
      logic need_load;
   } stat_type;

endpackage

// File: hdl/sixteen_bit_cpu_core.sv
// Top level of the 16-bit CPU core: controller plus datapath.
// rsp_valid comes in RESP, entered straight from IDLE for host functions and
// for execute while halted, via FETCH for a fetch fault, via FETCH and EXEC for
// execute and via FETCH, EXEC and LOAD for a load; busy holds until then, so no
// new transaction is taken before the response. Reset (synchronous) clears
// memory with busy high; config writes are taken throughout. CPU starts halted.
module sixteen_bit_cpu_core #(
   parameter int MEM_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [9:0]  req_address,
   input  logic [15:0] req_write_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_start_pc,
   output logic        rsp_valid,
   output logic [15:0] rsp_read_data,
   output logic [15:0] rsp_program_counter,
   output logic [2:0]  rsp_fault_code,
   output logic        rsp_halted,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_carry_flag,
   output logic        rsp_overflow_flag
);
   import s16c_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [9:0] start_pc_ff;
   logic [2:0] func_ff;
   logic [9:0] addr_ff;
   logic [3:0] flags;

   // config register: always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pc_ff <= 10'd0;
      end else if (csr_valid) begin
         start_pc_ff <= csr_start_pc;
      end
   end

   // hold the accepted command for later states
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         func_ff <= req_func;
         addr_ff <= req_address;
      end
   end

   s16c_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .func(req_func),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   s16c_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .func(busy ? func_ff : req_func),
      .address(busy ? addr_ff : req_address),
      .write_data(req_write_data), .start_pc(start_pc_ff), .stat(stat),
      .read_data(rsp_read_data), .program_counter(rsp_program_counter),
      .fault_code(rsp_fault_code), .halted(rsp_halted), .flags(flags)
   );

   assign rsp_valid         = cmd.rsp;
   assign rsp_zero_flag     = flags[0];
   assign rsp_sign_flag     = flags[1];
   assign rsp_carry_flag    = flags[2];
   assign rsp_overflow_flag = flags[3];
endmodule

// File: hdl/s16c_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module s16c_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// File: hdl/s16c_ctrl.sv
// Controller state machine of the 16-bit CPU core.
// Depends on s16c_pkg.
module s16c_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [2:0]         func,
   input  s16c_pkg::stat_type stat,
   output s16c_pkg::cmd_type  cmd,
   output logic               busy
);
   import s16c_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (func == FUNC_EXECUTE && !stat.halted) state_in = ST_FETCH;
               else state_in = ST_RESP;
            end
         end
         ST_FETCH: begin
            state_in = stat.fetch_ok ? ST_EXEC : ST_RESP;
         end
         ST_EXEC: begin
            state_in = stat.need_load ? ST_LOAD : ST_RESP;
         end
         ST_LOAD:  state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (func)
                  FUNC_WRITE_MEM: cmd.host_write = 1'b1;
                  FUNC_READ_MEM:  cmd.host_read  = 1'b1;
                  FUNC_READ_REG:  cmd.reg_read   = 1'b1;
                  FUNC_START:     cmd.start      = 1'b1;
                  default:        cmd.host_read  = 1'b0;
               endcase
            end
         end
         ST_FETCH: cmd.fetch   = 1'b1;
         ST_EXEC:  cmd.exec    = 1'b1;
         ST_LOAD:  cmd.load_wb = 1'b1;
         ST_RESP:  cmd.rsp     = 1'b1;
         default:  busy = 1'b1;
      endcase
   end
endmodule

// File: hdl/s16c_dp.sv
// Datapath of the 16-bit CPU core: memory, register file, pc, flags, ALU.
// Depends on s16c_pkg and s16c_ram.
module s16c_dp #(
   parameter int MEM_WORDS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  s16c_pkg::cmd_type  cmd,
   input  logic [2:0]         func,
   input  logic [9:0]         address,
   input  logic [15:0]        write_data,
   input  logic [9:0]         start_pc,
   output s16c_pkg::stat_type stat,
   output logic [15:0]        read_data,
   output logic [15:0]        program_counter,
   output logic [2:0]         fault_code,
   output logic               halted,
   output logic [3:0]         flags
);
   import s16c_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int CW = AW + 1;
   // one bit wider than a word so that a full 64K memory still compares
   localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff;
   logic [3:0]  flags_ff;   // {O,C,S,Z}
   logic        halt_ff;
   logic [2:0]  fault_ff;
   logic [15:0] rdat_ff;
   logic        rsel_mem_ff;  // response data comes from RAM output
   logic [2:0]  ld_reg_ff;
   logic [CW-1:0] clr_ff;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_wdata, ram_rdata;

   s16c_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr),
      .wdata(ram_wdata), .rdata(ram_rdata)
   );

   logic host_in_range;
   assign host_in_range = ({7'd0, address} < MEM_LIMIT);

   // decode
   logic [15:0] ins;
   logic [1:0]  cls;
   logic [2:0]  mcode, ra, rb, rc;
   logic [4:0]  acode;
   assign ins   = ram_rdata;
   assign cls   = ins[15:14];
   assign mcode = ins[13:11];
   assign acode = ins[13:9];

   logic [15:0] opa, opb, sum, res, off, target;
   logic [16:0] sum17;
   logic        add_op, logic_op, wr_reg, take, ovf;
   logic [2:0]  wr_idx;
   logic        mv_load;
   logic [2:0]  new_fault;
   logic [15:0] addr_reg;

   always_comb begin
      ra = 3'd0; rb = 3'd0; rc = 3'd0;
      if (cls == CLS_ALU) begin
         ra = ins[8:6]; rb = ins[5:3]; rc = ins[2:0];
      end else begin
         ra = ins[10:8]; rb = ins[7:5];
      end
   end

   always_comb begin
      opa = 16'd0; opb = 16'd0; add_op = 1'b0; logic_op = 1'b0;
      res = 16'd0; wr_reg = 1'b0; wr_idx = ra; new_fault = FAULT_NONE;
      take = 1'b0; off = 16'd0; mv_load = 1'b0; addr_reg = regs_ff[rb];
      case (cls)
         CLS_MOVE: begin
            case (mcode)
               MV_MOV:  begin res = regs_ff[rb]; wr_reg = 1'b1; end
               MV_LOAD: begin
                  addr_reg = regs_ff[rb];
                  if ({1'b0, addr_reg} < MEM_LIMIT) mv_load = 1'b1;
                  else new_fault = FAULT_READ;
               end
               MV_STORE: begin
                  addr_reg = regs_ff[ra];
                  if (!({1'b0, addr_reg} < MEM_LIMIT)) new_fault = FAULT_WRITE;
               end
               MV_MOVL: begin res = {regs_ff[ra][15:8], ins[7:0]}; wr_reg = 1'b1; end
               MV_MOVH: begin res = {ins[7:0], regs_ff[ra][7:0]}; wr_reg = 1'b1; end
               MV_NOP:  res = 16'd0;
               default: new_fault = FAULT_OPC;
            endcase
         end
         CLS_ALU: begin
            case (acode)
               ALU_ADD:  begin opa = regs_ff[rb]; opb = regs_ff[rc]; add_op = 1'b1; end
               ALU_SUB:  begin opa = regs_ff[rb]; opb = -regs_ff[rc]; add_op = 1'b1; end
               ALU_COMP: begin opa = regs_ff[ra]; opb = -regs_ff[rb]; add_op = 1'b1; end
               ALU_INC:  begin opa = regs_ff[ra]; opb = 16'd1; add_op = 1'b1; end
               ALU_DEC:  begin opa = regs_ff[ra]; opb = 16'hFFFF; add_op = 1'b1; end
               ALU_OR:   begin res = regs_ff[rb] | regs_ff[rc]; logic_op = 1'b1; end
               ALU_AND:  begin res = regs_ff[rb] & regs_ff[rc]; logic_op = 1'b1; end
               ALU_XOR:  begin res = regs_ff[rb] ^ regs_ff[rc]; logic_op = 1'b1; end
               ALU_NOT:  begin res = ~regs_ff[ra]; logic_op = 1'b1; end
               ALU_NEG:  begin res = -regs_ff[ra]; logic_op = 1'b1; end
               ALU_CLR:  begin res = 16'd0; logic_op = 1'b1; end
               default:  new_fault = FAULT_OPC;
            endcase
            wr_reg = (add_op && acode != ALU_COMP) || logic_op;
         end
         CLS_JUMP: begin
            off = {{2{ins[13]}}, ins[13:0]};
            take = 1'b1;
         end
         default: begin
            off = {{5{ins[10]}}, ins[10:0]};
            case (mcode)
               3'd0: take = flags_ff[2];
               3'd1: take = !flags_ff[2];
               3'd2: take = flags_ff[3];
               3'd3: take = !flags_ff[3];
               3'd4: take = flags_ff[0];
               3'd5: take = !flags_ff[0];
               3'd6: take = flags_ff[1];
               default: take = !flags_ff[1];
            endcase
         end
      endcase
      sum17 = {1'b0, opa} + {1'b0, opb};
      sum = sum17[15:0];
      if (add_op) res = sum;
      target = pc_ff + off;
      if (take && !({1'b0, target} < MEM_LIMIT)) new_fault = FAULT_JUMP;
   end

   assign ovf = (opa[15] == opb[15]) && (sum[15] != opa[15]);

   // memory port
   always_comb begin
      ram_we = 1'b0; ram_addr = AW'({6'd0, address}); ram_wdata = write_data;
      if (cmd.clr_step) begin
         ram_we = 1'b1; ram_addr = clr_ff[AW-1:0]; ram_wdata = 16'd0;
      end else if (cmd.host_write) begin
         ram_we = host_in_range;
      end else if (cmd.fetch) begin
         ram_addr = pc_ff[AW-1:0];
      end else if (cmd.exec) begin
         ram_addr = addr_reg[AW-1:0];
         ram_we = (cls == CLS_MOVE) && (mcode == MV_STORE) && (new_fault == FAULT_NONE);
         ram_wdata = regs_ff[rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         pc_ff <= 16'd0; flags_ff <= 4'd0; halt_ff <= 1'b1; fault_ff <= FAULT_NONE;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         rsel_mem_ff <= 1'b0; rdat_ff <= 16'd0; ld_reg_ff <= 3'd0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.host_write || cmd.start || (func != FUNC_READ_MEM && func != FUNC_READ_REG
             && !cmd.fetch && !cmd.exec && !cmd.load_wb && !cmd.rsp && !cmd.clr_step)) begin
            rsel_mem_ff <= 1'b0; rdat_ff <= 16'd0;
         end
         if (cmd.host_read) begin
            rsel_mem_ff <= host_in_range; rdat_ff <= 16'd0;
         end
         if (cmd.reg_read) begin
            rsel_mem_ff <= 1'b0; rdat_ff <= regs_ff[address[2:0]];
         end
         if (cmd.start) begin
            pc_ff <= {6'd0, start_pc}; flags_ff <= 4'd0;
            fault_ff <= FAULT_NONE; halt_ff <= 1'b0;
         end
         if (cmd.fetch) begin
            rsel_mem_ff <= 1'b0; rdat_ff <= 16'd0;
            if ({1'b0, pc_ff} < MEM_LIMIT) pc_ff <= pc_ff + 16'd1;
            else begin fault_ff <= FAULT_FETCH; halt_ff <= 1'b1; end
         end
         if (cmd.exec) begin
            if (new_fault != FAULT_NONE) begin
               fault_ff <= new_fault; halt_ff <= 1'b1;
            end else begin
               if (ins == STOP_WORD) halt_ff <= 1'b1;
               if (take) pc_ff <= target;
               if (wr_reg) regs_ff[wr_idx] <= res;
               if (add_op) flags_ff <= {ovf, sum17[16], res[15], res == 16'd0};
               if (logic_op) flags_ff <= {2'b00, res[15], res == 16'd0};
               ld_reg_ff <= ra;
            end
         end
         if (cmd.load_wb) regs_ff[ld_reg_ff] <= ram_rdata;
      end
   end

   assign stat.clr_done  = (clr_ff == CW'(MEM_WORDS - 1));
   assign stat.halted    = halt_ff;
   assign stat.fetch_ok  = ({1'b0, pc_ff} < MEM_LIMIT);
   assign stat.need_load = (cls == CLS_MOVE) && mv_load && (mcode == MV_LOAD);

   assign read_data       = rsel_mem_ff ? ram_rdata : rdat_ff;
   assign program_counter = pc_ff;
   assign fault_code      = fault_ff;
   assign halted          = halt_ff;
   assign flags           = flags_ff;
endmodule

// File: hdl/s16c_checker.sv
// Port-level checker for the 16-bit CPU core, bound to the top level.
// No dependencies.
module s16c_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_halted,
   input logic [2:0]  rsp_fault_code
);
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside transaction");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");
   a_fault_halt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault_code != 3'd0) |-> rsp_halted)
      else $error("fault without halt");
endmodule

bind sixteen_bit_cpu_core s16c_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_halted(rsp_halted), .rsp_fault_code(rsp_fault_code)
);
